// File: design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   localparam int REQ_BYTES_W = 13;
   localparam int ADDR_W      = 12;
   localparam int SIZE_W      = 13;

   typedef struct packed {
      logic                   operation;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]      free_address;
   } ffha_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_address;
      logic              status;
   } ffha_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FREE,
      ST_REPLY
   } ffha_state_type;

   typedef struct packed {
      logic accept;
      logic advance;
      logic grant;
      logic place;
      logic fail;
      logic do_free;
      logic rsp_load;
   } ffha_cmd_type;

   typedef struct packed {
      logic is_free_op;
      logic in_range;
      logic hit;
      logic size_zero;
      logic fits;
   } ffha_stat_type;

endpackage

// File: design/ffha_ctrl.sv
// Controller state machine of the first-fit heap allocator.
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  ffha_stat_type stat,
   output ffha_cmd_type  cmd
);

   ffha_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.is_free_op ? ST_FREE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (!stat.in_range || stat.hit || stat.size_zero) begin
               state_in = ST_REPLY;
            end
         end
         ST_FREE: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_WALK: begin
            if (stat.in_range && stat.hit) begin
               cmd.grant = 1'b1;
            end else if (!stat.in_range || stat.size_zero) begin
               // nothing reusable: append at heap end if there is room
               cmd.place = stat.fits;
               cmd.fail  = !stat.fits;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_FREE: begin
            cmd.do_free = 1'b1;
         end
         ST_REPLY: begin
            cmd.rsp_load = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/ffha_datapath.sv
// Datapath of the first-fit heap allocator: header memories, walk pointer, heap end.
module ffha_datapath
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 8
)
(
   input  logic          clock,
   input  logic          reset,
   input  ffha_req_type  req_payload,
   output ffha_rsp_type  rsp_payload,
   input  ffha_cmd_type  cmd,
   output ffha_stat_type stat
);

   localparam int AW = $clog2(HEAP_BYTES);
   localparam int VW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;

   logic              flag_mem [HEAP_BYTES];
   logic [SIZE_W-1:0] size_mem [HEAP_BYTES];

   logic [VW-1:0]     need_ff;
   logic [ADDR_W-1:0] free_addr_ff;
   logic [VW-1:0]     pos_ff, pos_in;
   logic [VW-1:0]     heap_end_ff, heap_end_in;
   logic              flag_rd_ff;
   logic [SIZE_W-1:0] size_rd_ff;
   ffha_rsp_type      result_ff, result_in;
   ffha_rsp_type      rsp_ff;

   logic [VW-1:0]     need_new;
   logic [VW-1:0]     free_hdr;
   logic              free_ok;
   logic              flag_we;
   logic [AW-1:0]     flag_wa;
   logic              flag_wd;

   assign need_new = VW'(req_payload.request_bytes) + VW'(HEADER_BYTES);
   assign free_hdr = VW'(free_addr_ff) - VW'(HEADER_BYTES);
   assign free_ok  = (VW'(free_addr_ff) >= VW'(HEADER_BYTES))
                     && (free_hdr < VW'(HEAP_BYTES));

   assign stat.is_free_op = (req_payload.operation == OP_FREE);
   assign stat.in_range   = (pos_ff < heap_end_ff) && (pos_ff < VW'(HEAP_BYTES));
   assign stat.hit        = flag_rd_ff && (VW'(size_rd_ff) >= need_ff);
   assign stat.size_zero  = (size_rd_ff == '0);
   assign stat.fits       = (heap_end_ff + need_ff <= VW'(HEAP_BYTES))
                            && (heap_end_ff + VW'(HEADER_BYTES) < VW'(HEAP_BYTES));

   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         pos_in = '0;
      end else if (cmd.advance) begin
         pos_in = pos_ff + VW'(size_rd_ff);
      end
   end

   assign heap_end_in = cmd.place ? (heap_end_ff + need_ff) : heap_end_ff;

   always_comb begin
      result_in = result_ff;
      if (cmd.grant) begin
         result_in.payload_address = ADDR_W'(pos_ff + VW'(HEADER_BYTES));
         result_in.status          = STATUS_DONE;
      end else if (cmd.place) begin
         result_in.payload_address = ADDR_W'(heap_end_ff + VW'(HEADER_BYTES));
         result_in.status          = STATUS_DONE;
      end else if (cmd.fail) begin
         result_in.payload_address = '0;
         result_in.status          = STATUS_NO_SPACE;
      end else if (cmd.do_free) begin
         result_in.payload_address = '0;
         result_in.status          = STATUS_DONE;
      end
   end

   // one write port on the flag memory; the commands are exclusive
   always_comb begin
      flag_we = 1'b0;
      flag_wa = pos_ff[AW-1:0];
      flag_wd = 1'b0;
      if (cmd.grant) begin
         flag_we = 1'b1;
      end else if (cmd.place) begin
         flag_we = 1'b1;
         flag_wa = heap_end_ff[AW-1:0];
      end else if (cmd.do_free) begin
         flag_we = free_ok;
         flag_wa = free_hdr[AW-1:0];
         flag_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[pos_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         size_mem[heap_end_ff[AW-1:0]] <= need_ff[SIZE_W-1:0];
      end
      size_rd_ff <= size_mem[pos_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_end_ff <= '0;
      end else begin
         heap_end_ff <= heap_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         need_ff      <= need_new;
         free_addr_ff <= req_payload.free_address;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= result_ff;
      end
      pos_ff    <= pos_in;
      result_ff <= result_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: design/first_fit_heap_allocator.sv
// First-fit heap allocator top level: controller plus datapath.
//   Requests arrive on req_valid/req_stall with req_payload. An allocate
//   request (operation = alloc) asks for request_bytes of payload; the block
//   adds HEADER_BYTES, walks the block headers from address zero and grants
//   the first available block that is large enough, else appends a block at
//   the heap end. The reply on rsp_valid/rsp_stall carries the address just
//   past the header, or status = no space with a zero address.
//   A free request marks the header HEADER_BYTES below free_address as
//   available (no coalescing) if that header lies in the heap, and
//   answers zero address, status done. One request is in work at a time;
//   req_stall is high while it is. A free passes ST_FREE then ST_REPLY;
//   an allocate walks in ST_WALK, one header per cycle, set by the single
//   read port of the header memories, then passes ST_REPLY. A new request
//   is taken only once the last one has left ST_REPLY.
//   A stalled reply holds in the output register; the next request can be
//   accepted and walked meanwhile, but waits before its own reply.
//   Reset clears the heap end and all handshake state; header memories are
//   not cleared, only entries of placed blocks are ever walked.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 8
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ffha_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ffha_rsp_type rsp_payload
);

   ffha_cmd_type  cmd;
   ffha_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// File: bench/tb_first_fit_heap_allocator.sv
// Self-checking testbench for the first-fit heap allocator: directed and random requests.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int HEAP_SIZE  = 4096;
   localparam int HDR_SIZE   = 8;
   localparam int ITEM_COUNT = 1700;
   localparam int CALM_AFTER = 1530;
   localparam int QUIET_MAX  = 4000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ffha_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   ffha_rsp_type rsp_payload;

   // shadow heap: flag and size per header address, plus the end of placed blocks
   bit                shadow_free [HEAP_SIZE];
   bit [SIZE_W-1:0]   shadow_size [HEAP_SIZE];
   int                shadow_end;

   ffha_req_type      requests_waiting [$];
   ffha_rsp_type      replies_due [$];
   logic [ADDR_W-1:0] live_blocks [$];

   int  failures;
   int  quiet_cycles;
   int  req_gap;
   int  stall_left;
   int  gap_odds;
   int  stall_odds;
   bit  req_fired;
   bit  calm;

   first_fit_heap_allocator #(
      .HEAP_BYTES   (HEAP_SIZE),
      .HEADER_BYTES (HDR_SIZE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one request to the shadow heap and returns the reply it should get.
   function automatic ffha_rsp_type predict_reply(ffha_req_type r);
      ffha_rsp_type rsp;
      int           need;
      int           pos;
      bit           found;
      rsp = '0;
      rsp.status = STATUS_DONE;
      found = 1'b0;
      if (r.operation == OP_ALLOC) begin
         need = int'(r.request_bytes) + HDR_SIZE;
         pos = 0;
         while (!found && pos < shadow_end && pos < HEAP_SIZE) begin
            if (shadow_free[pos] && int'(shadow_size[pos]) >= need) begin
               shadow_free[pos] = 1'b0;
               rsp.payload_address = ADDR_W'(pos + HDR_SIZE);
               found = 1'b1;
            end else if (shadow_size[pos] == 0) begin
               pos = HEAP_SIZE;
            end else begin
               pos += int'(shadow_size[pos]);
            end
         end
         if (!found) begin
            if (shadow_end + need > HEAP_SIZE || shadow_end + HDR_SIZE >= HEAP_SIZE) begin
               rsp.status = STATUS_NO_SPACE;
            end else begin
               shadow_free[shadow_end] = 1'b0;
               shadow_size[shadow_end] = SIZE_W'(need);
               rsp.payload_address = ADDR_W'(shadow_end + HDR_SIZE);
               shadow_end += need;
            end
         end
         if (rsp.status == STATUS_DONE)
            live_blocks.push_back(rsp.payload_address);
      end else if (int'(r.free_address) >= HDR_SIZE) begin
         shadow_free[int'(r.free_address) - HDR_SIZE] = 1'b1;
      end
      return rsp;
   endfunction

   task automatic queue_request(logic op, int nbytes, int addr);
      ffha_req_type r;
      r.operation     = op;
      r.request_bytes = REQ_BYTES_W'(nbytes);
      r.free_address  = ADDR_W'(addr);
      requests_waiting.push_back(r);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold the offered request until it is taken
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         req_gap = $urandom_range(1, 6) - 1;
      end else if (requests_waiting.size() > 0) begin
         req_valid   <= 1'b1;
         req_payload <= requests_waiting[0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // reply stall driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 6) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: checks replies, predicts accepted requests, watches for a hang
   always @(posedge clock) begin
      ffha_rsp_type want;
      bit           rsp_fired;
      if (!reset) begin
         rsp_fired = rsp_valid && !rsp_stall;
         if (rsp_fired) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected reply addr %0d status %0b", $time,
                        rsp_payload.payload_address, rsp_payload.status);
               failures++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_payload.payload_address !== want.payload_address) begin
                  $display("%0t: payload_address expected %0d actual %0d", $time,
                           want.payload_address, rsp_payload.payload_address);
                  failures++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0b actual %0b", $time,
                           want.status, rsp_payload.status);
                  failures++;
               end
            end
         end
         req_fired = req_valid && !req_stall;
         if (req_fired) begin
            replies_due.push_back(predict_reply(req_payload));
            void'(requests_waiting.pop_front());
         end
         quiet_cycles = (req_fired || rsp_fired) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("** first_fit_heap_allocator: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      int pick;
      int idx;
      int nbytes;
      int addr;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      shadow_end   = 0;
      failures     = 0;
      quiet_cycles = 0;
      req_gap      = 0;
      stall_left   = 0;
      gap_odds     = 4;
      stall_odds   = 4;
      req_fired    = 1'b0;
      calm         = 1'b0;
      counted      = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: size extremes, reuse without split, odd frees
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_ALLOC, HEAP_SIZE, 0);
      queue_request(OP_ALLOC, 8191, 0);
      queue_request(OP_ALLOC, 100, 0);
      queue_request(OP_FREE, 0, HDR_SIZE);
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_FREE, 0, 16);
      queue_request(OP_ALLOC, 50, 0);
      queue_request(OP_FREE, 0, 0);
      queue_request(OP_FREE, 0, HDR_SIZE - 1);
      queue_request(OP_FREE, 8191, 4095);
      queue_request(OP_FREE, 0, 16);
      queue_request(OP_FREE, 0, 16);
      queue_request(OP_FREE, 0, 20);
      queue_request(OP_ALLOC, 200, 0);
      queue_request(OP_ALLOC, 100, 0);
      queue_request(OP_ALLOC, 2000, 0);

      // random: mostly allocs and frees of granted blocks, some stray frees
      while (counted < ITEM_COUNT) begin
         while (requests_waiting.size() >= 3) @(posedge clock);
         if (counted % 100 == 0) begin
            gap_odds   = $urandom_range(0, 2) * 4;
            stall_odds = $urandom_range(0, 2) * 4;
         end
         if (counted >= CALM_AFTER)
            calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            addr = $urandom_range(0, HEAP_SIZE - 1);
            queue_request(OP_FREE, $urandom_range(0, 8191), addr);
            if (addr >= HDR_SIZE)
               counted++;
         end else if (pick < 45 && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            addr = live_blocks[idx];
            live_blocks.delete(idx);
            queue_request(OP_FREE, $urandom_range(0, 8191), addr);
            counted++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               nbytes = $urandom_range(0, 31);
            else if (pick < 85)
               nbytes = $urandom_range(32, 255);
            else if (pick < 95)
               nbytes = $urandom_range(256, 1023);
            else if (pick < 98)
               // aim for an exact fit at the heap end
               nbytes = (shadow_end + HDR_SIZE <= HEAP_SIZE) ?
                        HEAP_SIZE - shadow_end - HDR_SIZE : 0;
            else
               nbytes = $urandom_range(0, 8191);
            queue_request(OP_ALLOC, nbytes, $urandom_range(0, HEAP_SIZE - 1));
            counted++;
         end
      end

      while (requests_waiting.size() > 0 || replies_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("** first_fit_heap_allocator: PASSED **");
      else
         $display("** first_fit_heap_allocator: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
design/ffha_pkg.sv
design/ffha_ctrl.sv
design/ffha_datapath.sv
design/first_fit_heap_allocator.sv
bench/tb_first_fit_heap_allocator.sv
